FILE: rtl/atrf_pkg.sv
// ----------------------------------------------------------------------------
// atrf_pkg
// Shared types, register indexes and sequencer step codes for the API
// transmit-request framer.
// ----------------------------------------------------------------------------
package atrf_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int ADDR64_W  = 64;
    localparam int ADDR16_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Default queue depths
    localparam int CMD_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR64 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR16 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] FRAME_TYPE_RST = 8'h10;

    // Frame constants
    localparam logic [BYTE_W-1:0] DELIMITER   = 8'h7E;
    localparam logic [BYTE_W-1:0] FRAME_ID    = 8'h02;
    localparam logic [BYTE_W-1:0] OPTIONS     = 8'h00;
    localparam logic [15:0]       LEN_OVERHEAD = 16'd14;

    // Sequencer steps of one frame
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_DELIM  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LEN_HI = 5'd1;
    localparam logic [STEP_W-1:0] STEP_LEN_LO = 5'd2;
    localparam logic [STEP_W-1:0] STEP_TYPE   = 5'd3;
    localparam logic [STEP_W-1:0] STEP_ID     = 5'd4;
    localparam logic [STEP_W-1:0] STEP_A64_0  = 5'd5;
    localparam logic [STEP_W-1:0] STEP_A64_7  = 5'd12;
    localparam logic [STEP_W-1:0] STEP_A16_HI = 5'd13;
    localparam logic [STEP_W-1:0] STEP_A16_LO = 5'd14;
    localparam logic [STEP_W-1:0] STEP_RADIUS = 5'd15;
    localparam logic [STEP_W-1:0] STEP_OPTS   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_DATA   = 5'd17;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 5'd18;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              frame_end;
    } out_item_t;

    // Classified transaction handed from front to back
    typedef struct packed {
        logic              start;
        logic              has_data;
        logic              do_check;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] length;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   frame_type;
        logic [ADDR64_W-1:0] dest_addr64;
        logic [ADDR16_W-1:0] dest_addr16;
        logic [BYTE_W-1:0]   radius;
    } cfg_t;

endpackage

FILE: rtl/atrf_regs.sv
// ----------------------------------------------------------------------------
// atrf_regs
// Configuration register file: decodes the write port into frame settings.
// ----------------------------------------------------------------------------
module atrf_regs
    import atrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Decode register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_type  <= FRAME_TYPE_RST;
            cfg_reg.dest_addr64 <= '0;
            cfg_reg.dest_addr16 <= '0;
            cfg_reg.radius      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_TYPE:  cfg_reg.frame_type  <= cfg_data[BYTE_W-1:0];
                REG_DEST_ADDR64: cfg_reg.dest_addr64 <= cfg_data[ADDR64_W-1:0];
                REG_DEST_ADDR16: cfg_reg.dest_addr16 <= cfg_data[ADDR16_W-1:0];
                REG_RADIUS:      cfg_reg.radius      <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/atrf_fifo.sv
// ----------------------------------------------------------------------------
// atrf_fifo
// Small synchronous queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module atrf_fifo
    import atrf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: rtl/atrf_front.sv
// ----------------------------------------------------------------------------
// atrf_front
// Accepts input transactions, tracks frame position and classifies each one
// into header / payload / checksum work for the back end.
// ----------------------------------------------------------------------------
module atrf_front
    import atrf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t request,
    output logic     full,
    output logic     cmd_push,
    output cmd_t     cmd,
    input  logic     cmd_full
);

    logic [BYTE_W-1:0] bytes_taken_reg, bytes_taken_next;
    logic [BYTE_W-1:0] frame_length_reg, frame_length_next;
    logic              accept;
    logic              start;
    logic [BYTE_W-1:0] length;
    logic [BYTE_W-1:0] taken_after;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    // Classify the incoming transaction
    always_comb
    begin
        start       = (bytes_taken_reg == '0);
        length      = start ? request.payload_length : frame_length_reg;
        taken_after = bytes_taken_reg + BYTE_W'(length != '0);

        cmd.start     = start;
        cmd.has_data  = (length != '0);
        cmd.do_check  = (taken_after >= length);
        cmd.data_byte = request.data_byte;
        cmd.length    = length;

        frame_length_next = length;
        bytes_taken_next  = cmd.do_check ? '0 : taken_after;
    end

    // Advance frame position on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken_reg  <= '0;
            frame_length_reg <= '0;
        end
        else if (accept)
        begin
            bytes_taken_reg  <= bytes_taken_next;
            frame_length_reg <= frame_length_next;
        end
    end

endmodule

FILE: rtl/atrf_back.sv
// ----------------------------------------------------------------------------
// atrf_back
// Byte sequencer: walks each classified transaction through header, payload
// and checksum steps, one byte per cycle unless out_full; keeps the checksum.
// ----------------------------------------------------------------------------
module atrf_back
    import atrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    output logic      out_push,
    output out_item_t out_item,
    input  logic      out_full
);

    cmd_t              cur_reg;
    logic              cur_valid_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              fire;
    logic              last;
    logic [BYTE_W-1:0] byte_val;
    logic [15:0]       total;
    logic [2:0]        a64_idx;
    logic [STEP_W-1:0] a64_off;
    logic [STEP_W-1:0] first_step;

    assign fire     = cur_valid_reg && !out_full;
    assign out_push = fire;
    assign total    = 16'(cur_reg.length) + LEN_OVERHEAD;
    assign a64_off  = step_reg - STEP_A64_0;
    assign a64_idx  = a64_off[2:0];

    // Pick the byte of the current step
    always_comb
    begin
        byte_val = OPTIONS;
        unique case (step_reg) inside
            STEP_DELIM:  byte_val = DELIMITER;
            STEP_LEN_HI: byte_val = total[15:8];
            STEP_LEN_LO: byte_val = total[7:0];
            STEP_TYPE:   byte_val = cfg.frame_type;
            STEP_ID:     byte_val = FRAME_ID;
            [STEP_A64_0:STEP_A64_7]:
                byte_val = cfg.dest_addr64[{~a64_idx, 3'b000} +: BYTE_W];
            STEP_A16_HI: byte_val = cfg.dest_addr16[15:8];
            STEP_A16_LO: byte_val = cfg.dest_addr16[7:0];
            STEP_RADIUS: byte_val = cfg.radius;
            STEP_OPTS:   byte_val = OPTIONS;
            STEP_DATA:   byte_val = cur_reg.data_byte;
            STEP_CHECK:  byte_val = ~sum_reg;
            default:     byte_val = OPTIONS;
        endcase
    end

    // Find the step order and the last byte of the transaction
    always_comb
    begin
        last = (step_reg == STEP_CHECK)
            || ((step_reg == STEP_DATA) && !cur_reg.do_check);

        if (step_reg == STEP_OPTS)
            step_next = cur_reg.has_data ? STEP_DATA : STEP_CHECK;
        else if (step_reg == STEP_DATA)
            step_next = STEP_CHECK;
        else
            step_next = step_reg + 1'b1;

        if (cmd.start)
            first_step = STEP_DELIM;
        else if (cmd.has_data)
            first_step = STEP_DATA;
        else
            first_step = STEP_CHECK;

        cmd_pop = !cmd_empty && (!cur_valid_reg || (fire && last));

        out_item.out_byte  = byte_val;
        out_item.run_last  = last;
        out_item.frame_end = (step_reg == STEP_CHECK);
    end

    // Accumulate checksum from frame type through payload
    always_comb
    begin
        sum_next = sum_reg;
        if (fire)
        begin
            if (step_reg == STEP_DELIM || step_reg == STEP_CHECK)
                sum_next = '0;
            else if (step_reg >= STEP_TYPE && step_reg <= STEP_DATA)
                sum_next = sum_reg + byte_val;
        end
    end

    // Load, advance or retire the current transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_DELIM;
            sum_reg       <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (cmd_pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= first_step;
            end
            else if (fire && last)
                cur_valid_reg <= 1'b0;
            else if (fire)
                step_reg <= step_next;
        end
    end

    // Hold the transaction payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= cmd;
    end

endmodule

FILE: rtl/api_tx_request_framer_top.sv
// ----------------------------------------------------------------------------
// api_tx_request_framer_top
// Builds API transmit-request frames as a byte stream.
//
// Usage: write frame_type, dest_addr64, dest_addr16 and radius through the
// cfg_we / cfg_index / cfg_data port while the block is idle. Push one input
// transaction per payload byte (payload_length read on the first one of a
// frame; a zero length frame is a single transaction). Results leave through
// a queue interface: while empty is low the oldest byte sits on result, and
// pop takes it.
// A taken transaction passes through the command queue and the sequencer's
// current-transaction register into the result queue. Throughput: the byte
// sequencer emits one byte per cycle while the result queue has room; a
// frame-start transaction yields 17 header bytes and its payload byte if
// any, every later one its payload byte, and one closing a frame the
// checksum too. The command queue (CMD_DEPTH entries) lets push continue
// while the header burst drains. When the receiver stalls, the result queue
// fills, the sequencer holds, then the command queue fills and full rises.
// Reset empties both queues, restarts framing and loads register defaults.
// ----------------------------------------------------------------------------
module api_tx_request_framer_top
    import atrf_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  in_item_t             request,
    output logic                 full,
    input  logic                 pop,
    output out_item_t            result,
    output logic                 empty,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t      cfg;
    cmd_t      front_cmd;
    cmd_t      back_cmd;
    logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
    out_item_t out_item;
    logic      out_push, out_full;

    atrf_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    atrf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (front_cmd),
        .cmd_full (cmd_full)
    );

    atrf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    atrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_push  (out_push),
        .out_item  (out_item),
        .out_full  (out_full)
    );

    atrf_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
